// File: rtl/core/tpbe_pkg.sv
// Shared types and constants for the tile palette bitplane encoder.
package tpbe_pkg;

	localparam int unsigned TILE_SIZE = 8;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned COLOUR_W  = 6;
	localparam int unsigned PLANES    = 4;

	typedef logic [COLOUR_W-1:0] colour_t;
	typedef logic [IDX_W-1:0]    index_t;

	// Status that each palette cell reports to the top level
	typedef struct packed {
		logic valid;
		logic match;
	} pal_stat_t;

endpackage

// File: rtl/core/tpbe_pal_cell.sv
// One palette cell: holds one colour entry, compares it, and fills after its left neighbor.
module tpbe_pal_cell
	import tpbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  colour_t   colour,
	input  logic      add_en,
	input  logic      prev_valid,
	output pal_stat_t stat
);

	logic    valid_q;
	colour_t entry_q;
	logic    load;

	// Take the new colour when the neighbor is filled and this cell is the first free one
	assign load = add_en && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= colour;
		end
	end

	assign stat.valid = valid_q;
	assign stat.match = valid_q && (entry_q == colour);

endmodule

// File: rtl/core/tpbe_plane_cell.sv
// One pixel cell of the line shift chain: holds a 4-bit index and hands it on each beat.
module tpbe_plane_cell
	import tpbe_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  index_t din,
	output index_t dout
);

	index_t idx_q;

	// Advance the chain by one pixel per accepted beat
	always_ff @(posedge clk) begin
		if (en) begin
			idx_q <= din;
		end
	end

	assign dout = idx_q;

endmodule

// File: rtl/core/tile_palette_bitplane_encoder_core.sv
// Top level: 4bpp planar tile encoder with a learned palette built from rows of cells.
// Each accepted input beat leaves its result beat on the output register in the next cycle.
// Throughput: one pixel per cycle unless the output stalls; the palette compare across the
// cell row and the index encode sit in the single stage before the output register.
// Reset clears the tile position counters, tile number, palette valid bits and fill
// count, the sticky overflow flag and the output valid; no clearing pass is needed.
module tile_palette_bitplane_encoder_core
	import tpbe_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
	input  logic [31:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: colour_index[3:0], added_colour_6bit[9:4], added_colour_12bit[21:10],
	//          line_word[53:22], tile_number[69:54], palette_overflow[70], zero[71]
	output logic [71:0] m_tdata,
	// m_tuser: colour_added[0], line_ready[1]
	output logic [1:0]  m_tuser,
	// m_tlast: tile_done
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam int unsigned POS_W = $clog2(TILE_SIZE);
	localparam int unsigned CHAIN = TILE_SIZE - 1;

	// Control state
	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [15:0]      tile_q;
	logic             ovf_q;
	logic             m_tvalid_q;

	// Output register payload
	logic [71:0]      tdata_s1;
	logic [1:0]       tuser_s1;
	logic             tlast_s1;

	logic             s_accept;
	logic             opaque;
	colour_t          colour;
	pal_stat_t        stat [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] valid_vec;
	logic [PALETTE_DEPTH-1:0] match_vec;
	logic             found;
	index_t           match_idx;
	logic             full;
	logic             add;
	logic             ovf_next;
	index_t           idx;
	logic             line_end;
	logic             tile_end;
	index_t           chain [CHAIN];
	logic [31:0]      word;
	logic [11:0]      colour12;

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;

	// Cut the pixel to a 6-bit colour
	assign opaque = (s_tdata[31:24] != 8'd0);
	assign colour = {s_tdata[23:22], s_tdata[15:14], s_tdata[7:6]};

	// Palette cell row
	genvar gi;
	generate
		for (gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_pal
			if (gi == 0) begin : g_first
				tpbe_pal_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.colour    (colour),
					.add_en    (add && s_accept),
					.prev_valid(1'b1),
					.stat      (stat[gi])
				);
			end else begin : g_rest
				tpbe_pal_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.colour    (colour),
					.add_en    (add && s_accept),
					.prev_valid(stat[gi-1].valid),
					.stat      (stat[gi])
				);
			end
			assign valid_vec[gi] = stat[gi].valid;
			assign match_vec[gi] = stat[gi].match;
		end
	endgenerate

	// Encode the matching cell; entries are distinct so at most one matches
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < PALETTE_DEPTH; i++) begin
			if (match_vec[i]) begin
				match_idx = match_idx | IDX_W'(i);
			end
		end
	end

	assign found    = |match_vec;
	assign full     = (count_q == CNT_W'(PALETTE_DEPTH));
	assign add      = opaque && !found && !full;
	assign ovf_next = ovf_q || (opaque && !found && full);

	// Pick the pixel index
	always_comb begin
		idx = '0;
		if (opaque) begin
			if (found) begin
				idx = match_idx;
			end else if (!full) begin
				idx = IDX_W'(count_q);
			end
		end
	end

	assign line_end = (col_q == POS_W'(TILE_SIZE - 1));
	assign tile_end = line_end && (row_q == POS_W'(TILE_SIZE - 1));

	// Line shift chain of pixel cells
	generate
		for (gi = 0; gi < CHAIN; gi++) begin : g_line
			if (gi == 0) begin : g_first
				tpbe_plane_cell u_cell (
					.clk (clk),
					.en  (s_accept),
					.din (idx),
					.dout(chain[gi])
				);
			end else begin : g_rest
				tpbe_plane_cell u_cell (
					.clk (clk),
					.en  (s_accept),
					.din (chain[gi-1]),
					.dout(chain[gi])
				);
			end
		end
	endgenerate

	// Spread the row over the planes; pixel 0 sits in the oldest cell
	always_comb begin
		word = '0;
		if (line_end) begin
			for (int p = 0; p < PLANES; p++) begin
				word[p*8] = idx[p];
				for (int j = 0; j < CHAIN; j++) begin
					word[p*8 + (TILE_SIZE - 1 - j)] = chain[CHAIN - 1 - j][p];
				end
			end
		end
	end

	// Each 2-bit channel times 5 is the channel repeated in a nibble
	assign colour12 = {colour[5:4], colour[5:4], colour[3:2], colour[3:2],
	                   colour[1:0], colour[1:0]};

	// Advance position, tile number, fill count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			tile_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (s_accept) begin
			if (add) begin
				count_q <= count_q + CNT_W'(1);
			end
			ovf_q <= ovf_next;
			if (line_end) begin
				col_q <= '0;
				if (tile_end) begin
					row_q  <= '0;
					tile_q <= tile_q + 16'd1;
				end else begin
					row_q <= row_q + POS_W'(1);
				end
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (s_accept) begin
			tdata_s1 <= {1'b0, ovf_next, tile_q, word,
			             add ? colour12 : 12'd0,
			             add ? colour : '0,
			             idx};
			tuser_s1 <= {line_end, add};
			tlast_s1 <= tile_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_s1;
	assign m_tuser  = tuser_s1;
	assign m_tlast  = tlast_s1;

	// Fill count never passes the palette depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PALETTE_DEPTH))
		else $error("palette count beyond depth");

	// Valid cells track the fill count
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("palette valid bits disagree with count");

	// Entries stay distinct
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("several palette entries match");

	// Overflow flag is sticky
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag cleared");

endmodule
